>>> rtl/clq_pkg.sv
// Shared types and constants for the clique membership test unit.
// No dependencies; imported by clique_membership_test_unit.
`default_nettype none

package clq_pkg;

   localparam int MAX_NODES_DEFAULT = 256;
   localparam int NODE_W            = 8;
   localparam int COUNT_W           = 9;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

   localparam logic [1:0] REQ_EDGE   = 2'd0;
   localparam logic [1:0] REQ_MEMBER = 2'd1;
   localparam logic [1:0] REQ_TEST   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_TEST,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic              bit_value;
   } req_beat_type;

   typedef struct packed {
      logic               all_adjacent;
      logic [COUNT_W-1:0] member_count;
   } rsp_beat_type;

endpackage

`default_nettype wire

>>> rtl/clique_membership_test_unit.sv
// Clique membership test unit: adjacency matrix in one row-wide memory,
// membership vector and test walk in flip-flops. Depends on clq_pkg.
//
//   channel | direction | beat
//   req_    | in        | req_beat_type: request code, two nodes, bit value
//   rsp_    | out       | rsp_beat_type: clique flag, member count
//   csr_    | in        | 9-bit node count
//
// Edge write: a read-modify-write of the row of each node (one row when both nodes
// match) through the single memory port. Test: a walk from row 0 up to the highest
// member index below node count, one row read per cycle. After reset a clearing
// pass writes zero to all MAX_NODES rows, one per cycle, before requests are taken;
// csr_ is open throughout. A finished result waits in the output register while new
// beats are taken; only a completed test holds.
`default_nettype none

module clique_membership_test_unit
   import clq_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire req_beat_type       req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      rsp_beat_type       rsp_data,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int LIM_RW = $clog2(MAX_NODES + 1);
   localparam int LIM_W  = (LIM_RW > COUNT_W) ? LIM_RW : COUNT_W;
   localparam logic [MAX_NODES-1:0] ONE_BIT   = MAX_NODES'(1);
   localparam logic [IDX_W-1:0]     LAST_ROW  = IDX_W'(MAX_NODES - 1);
   localparam logic [LIM_W-1:0]     MAX_LIMIT = LIM_W'(MAX_NODES);

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic [IDX_W-1:0]       a_ff, a_in;
   logic [IDX_W-1:0]       b_ff, b_in;
   logic                   v_ff, v_in;
   logic [MAX_NODES-1:0]   member_ff, member_in;
   logic [MAX_NODES-1:0]   pend_ff, pend_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   logic                   ok_ff, ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_beat_type           rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]     node_count_ff, node_count_in;

   logic [MAX_NODES-1:0]   adj_mem [MAX_NODES];
   logic [MAX_NODES-1:0]   rd_data_ff;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [MAX_NODES-1:0]   wr_data;

   logic [LIM_W-1:0]       node_lim;
   logic [LIM_W-1:0]       n_lim;
   logic [MAX_NODES-1:0]   lt_mask;
   logic [LIM_W-1:0]       a_lim, b_lim;
   logic                   a_ok, b_ok;
   logic [IDX_W-1:0]       a_idx, b_idx;
   logic [MAX_NODES-1:0]   sel, pend_next;
   logic                   accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign node_lim = LIM_W'(node_count_ff);
   assign n_lim    = (node_lim < MAX_LIMIT) ? node_lim : MAX_LIMIT;
   assign a_lim    = LIM_W'(req_data.node_a);
   assign b_lim    = LIM_W'(req_data.node_b);
   assign a_ok     = a_lim < n_lim;
   assign b_ok     = b_lim < n_lim;
   assign a_idx    = a_lim[IDX_W-1:0];
   assign b_idx    = b_lim[IDX_W-1:0];

   always_comb begin
      for (int k = 0; k < MAX_NODES; k++) begin
         lt_mask[k] = LIM_W'(k) < n_lim;
      end
   end

   assign sel       = ONE_BIT << idx_ff;
   assign pend_next = pend_ff & ~sel;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      v_in          = v_ff;
      member_in     = member_ff;
      pend_in       = pend_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      ok_in         = ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      node_count_in = csr_valid ? csr_data : node_count_ff;
      rd_en         = 1'b0;
      rd_addr       = a_idx;
      wr_en         = 1'b0;
      wr_addr       = a_ff;
      wr_data       = rd_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_EDGE: begin
                     if (a_ok && b_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = a_idx;
                        a_in     = a_idx;
                        b_in     = b_idx;
                        v_in     = req_data.bit_value;
                        state_in = ST_EDGE_A;
                     end
                  end
                  REQ_MEMBER: begin
                     if (a_ok) begin
                        member_in[a_idx] = req_data.bit_value;
                     end
                  end
                  REQ_TEST: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     cnt_in   = '0;
                     ok_in    = 1'b1;
                     pend_in  = member_ff & lt_mask;
                     state_in = (|(member_ff & lt_mask)) ? ST_TEST : ST_RESULT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE_A: begin
            wr_en   = 1'b1;
            wr_addr = a_ff;
            wr_data = v_ff ? (rd_data_ff | (ONE_BIT << b_ff))
                           : (rd_data_ff & ~(ONE_BIT << b_ff));
            if (a_ff != b_ff) begin
               rd_en    = 1'b1;
               rd_addr  = b_ff;
               state_in = ST_EDGE_B;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EDGE_B: begin
            wr_en    = 1'b1;
            wr_addr  = b_ff;
            wr_data  = v_ff ? (rd_data_ff | (ONE_BIT << a_ff))
                            : (rd_data_ff & ~(ONE_BIT << a_ff));
            state_in = ST_IDLE;
         end
         ST_TEST: begin
            // row idx_ff is in rd_data_ff; members above it must all be adjacent
            if (|(pend_ff & sel)) begin
               cnt_in = cnt_ff + COUNT_W'(1);
               ok_in  = ok_ff && !(|(pend_next & ~rd_data_ff));
            end
            pend_in = pend_next;
            idx_in  = idx_ff + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_ff + IDX_W'(1);
            if (!(|pend_next)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.all_adjacent = ok_ff;
               rsp_data_in.member_count = cnt_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         member_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         clr_ff        <= clr_in;
         member_ff     <= member_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      v_ff        <= v_in;
      pend_ff     <= pend_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= adj_mem[rd_addr];
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result beat raised outside result state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (LIM_W'(rsp_data_ff.member_count) <= n_lim))
      else $error("member count above node count");

   a_walk_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) |-> (|pend_ff))
      else $error("test walk with no members left");

   a_second_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDGE_B) |-> (a_ff != b_ff))
      else $error("second row update for a self-loop");

   a_ready_after_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR) && (clr_ff == LAST_ROW)) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not finish");
`endif

endmodule

`default_nettype wire
